// File: rtl/ustr_pkg.sv
// Shared types and constants for the unordered swap-remove table.
package ustr_pkg;

  localparam int Capacity   = 64;
  localparam int ValueWidth = 32;
  localparam int IdxWidth   = $clog2(Capacity);
  localparam int CntWidth   = $clog2(Capacity + 1);
  localparam int QueueDepth = 2;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_REMGRP = 3'd2,
    ACT_FIND   = 3'd3,
    ACT_ITER   = 3'd4,
    ACT_CLEAR  = 3'd5,
    ACT_NOP6   = 3'd6,
    ACT_NOP7   = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_BADINDEX = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    action_t               action;
    logic [ValueWidth-1:0] item_value;
    logic [IdxWidth-1:0]   slot_index;
  } request_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [IdxWidth-1:0]   out_index;
    logic [ValueWidth-1:0] out_value;
    logic [CntWidth-1:0]   entry_count;
    logic                  group_end;
    logic                  last;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SCAN_CHK,
    S_RD_SRC,
    S_WR_DST,
    S_ITER_RD,
    S_ITER_OUT,
    S_EMIT
  } state_t;

endpackage

// File: rtl/ustr_front.sv
// Front end: request capture queue between the input port and the table engine.
module ustr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ustr_pkg::request_t in_req,
  output logic              q_valid,
  input  logic              q_pop,
  output ustr_pkg::request_t q_req
);
  import ustr_pkg::*;

  localparam int PtrWidth = $clog2(QueueDepth);

  request_t            mem [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [PtrWidth:0]   fill;
  logic                push;

  assign in_stall = (fill == (PtrWidth + 1)'(QueueDepth)) ? 1'b1 : 1'b0;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign q_req    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (PtrWidth + 1)'(push) - (PtrWidth + 1)'(q_pop);
    end
  end

endmodule

// File: rtl/ustr_back.sv
// Back end: table store, fill count and the sequencer that carries out each request.
module ustr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_wdata,
  input  logic               q_valid,
  output logic               q_pop,
  input  ustr_pkg::request_t q_req,
  output logic               out_valid,
  input  logic               out_stall,
  output ustr_pkg::result_t  out_res
);
  import ustr_pkg::*;

  logic [ValueWidth-1:0] store [Capacity];
  logic [ValueWidth-1:0] rd_data;
  logic                  rd_en;
  logic [IdxWidth-1:0]   rd_addr;
  logic                  wr_en;
  logic [IdxWidth-1:0]   wr_addr;
  logic [ValueWidth-1:0] wr_data;

  state_t                state, state_next;
  request_t              req;
  logic [CntWidth-1:0]   count, count_next;
  logic [2:0]            group_size;
  logic [2:0]            gsz;
  logic [CntWidth-1:0]   ptr;
  logic [2:0]            step;
  logic [2:0]            moves;
  logic [2:0]            gpos;
  logic [IdxWidth-1:0]   found;
  logic [IdxWidth-1:0]   src_base;
  logic                  hit;
  logic                  fits;
  result_t               res, res_next;
  logic                  res_load;
  logic                  out_full;
  logic                  out_free;
  logic                  scan_hit;
  logic                  ptr_last;
  logic                  grp_fits;
  logic                  rem_ok;

  assign gsz       = (group_size == 3'd0) ? 3'd1 : group_size;
  assign out_free  = !out_full || !out_stall;
  assign out_valid = out_full;
  assign out_res   = res;
  assign scan_hit  = (rd_data == req.item_value);
  assign ptr_last  = (ptr + CntWidth'(1) == count);
  assign grp_fits  = (count >= CntWidth'(gsz)) && (ptr + CntWidth'(gsz) <= count);
  assign rem_ok    = (count != '0) && (CntWidth'(req.slot_index) < count);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (q_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        unique case (req.action) inside
          ACT_REMOVE:           state_next = rem_ok ? S_RD_SRC : S_EMIT;
          ACT_REMGRP, ACT_FIND: state_next = (count == '0) ? S_EMIT : S_SCAN;
          ACT_ITER:             state_next = (count == '0) ? S_EMIT : S_ITER_RD;
          default:              state_next = S_EMIT;
        endcase
      end
      S_SCAN:     state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (scan_hit) begin
          state_next = (req.action == ACT_REMGRP && grp_fits) ? S_RD_SRC : S_EMIT;
        end else if (ptr_last) begin
          state_next = S_EMIT;
        end
      end
      S_RD_SRC:   state_next = S_WR_DST;
      S_WR_DST:   state_next = (step + 3'd1 == moves) ? S_EMIT : S_RD_SRC;
      S_ITER_RD:  state_next = S_ITER_OUT;
      S_ITER_OUT: if (out_free) state_next = ptr_last ? S_IDLE : S_ITER_RD;
      S_EMIT:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = (state == S_IDLE) && q_valid;
    rd_en      = 1'b0;
    rd_addr    = ptr[IdxWidth-1:0];
    wr_en      = 1'b0;
    wr_addr    = found + IdxWidth'(step);
    wr_data    = rd_data;
    res_load   = 1'b0;
    res_next   = res;
    count_next = count;
    unique case (state)
      S_SCAN, S_ITER_RD: rd_en = 1'b1;
      S_SCAN_CHK: begin
        rd_en   = 1'b1;
        rd_addr = ptr[IdxWidth-1:0] + IdxWidth'(1);
      end
      S_RD_SRC: begin
        rd_en   = 1'b1;
        rd_addr = src_base + IdxWidth'(step);
      end
      S_WR_DST: wr_en = 1'b1;
      S_ITER_OUT: begin
        if (out_free) begin
          res_load             = 1'b1;
          res_next.status      = ST_OK;
          res_next.out_index   = ptr[IdxWidth-1:0];
          res_next.out_value   = rd_data;
          res_next.entry_count = count;
          res_next.group_end   = (gpos == gsz) || ptr_last;
          res_next.last        = ptr_last;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          res_load             = 1'b1;
          res_next             = '0;
          res_next.last        = 1'b1;
          res_next.entry_count = count;
          unique case (req.action)
            ACT_ADD: begin
              if (count == CntWidth'(Capacity)) begin
                res_next.status = ST_FULL;
              end else begin
                wr_en                = 1'b1;
                wr_addr              = count[IdxWidth-1:0];
                wr_data              = req.item_value;
                res_next.out_index   = count[IdxWidth-1:0];
                res_next.entry_count = count + CntWidth'(1);
                count_next           = count + CntWidth'(1);
              end
            end
            ACT_REMOVE: begin
              res_next.out_index = req.slot_index;
              if (count == '0) begin
                res_next.status = ST_EMPTY;
              end else if (!rem_ok) begin
                res_next.status = ST_BADINDEX;
              end else begin
                res_next.entry_count = count - CntWidth'(1);
                count_next           = count - CntWidth'(1);
              end
            end
            ACT_REMGRP: begin
              if (!hit) begin
                res_next.status = ST_NOTFOUND;
              end else if (!fits) begin
                res_next.status    = ST_BADINDEX;
                res_next.out_index = found;
              end else begin
                res_next.out_index   = found;
                res_next.entry_count = count - CntWidth'(moves);
                count_next           = count - CntWidth'(moves);
              end
            end
            ACT_FIND: begin
              if (hit) begin
                res_next.out_index = found;
              end else begin
                res_next.status = ST_NOTFOUND;
              end
            end
            ACT_ITER: res_next.status = ST_EMPTY;
            ACT_CLEAR: begin
              res_next.entry_count = '0;
              count_next           = '0;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      group_size <= 3'd1;
      out_full   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) begin
        group_size <= cfg_wdata;
      end
      if (res_load) begin
        out_full <= 1'b1;
      end else if (!out_stall) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      req <= q_req;
    end
    if (res_load) begin
      res <= res_next;
    end
    unique case (state)
      S_DISPATCH: begin
        ptr      <= '0;
        step     <= '0;
        gpos     <= 3'd1;
        hit      <= 1'b0;
        fits     <= 1'b0;
        found    <= req.slot_index;
        src_base <= IdxWidth'(count - CntWidth'(1));
        moves    <= 3'd1;
      end
      S_SCAN_CHK: begin
        if (scan_hit) begin
          hit      <= 1'b1;
          fits     <= grp_fits;
          found    <= ptr[IdxWidth-1:0];
          src_base <= IdxWidth'(count - CntWidth'(gsz));
          moves    <= gsz;
        end else begin
          ptr <= ptr + CntWidth'(1);
        end
      end
      S_WR_DST: step <= step + 3'd1;
      S_ITER_OUT: begin
        if (out_free) begin
          ptr  <= ptr + CntWidth'(1);
          gpos <= (gpos == gsz) ? 3'd1 : gpos + 3'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/unordered_swap_remove_table.sv
// Top level of the unordered swap-remove table.
//
// Requests enter on in_valid / in_stall with action, item_value and
// slot_index; results leave on out_valid / out_stall, one per request
// except iterate, which streams one result per stored entry (a single
// empty result on an empty table). The final result of a request has last set.
// group_size is written through cfg_we / cfg_wdata; the user must do so
// only while no request is in flight; the block itself does not enforce it.
// A two-entry queue takes requests while the engine handles one at a time.
// Add, clear, unused codes and rejected requests go straight to the result;
// remove at index first copies the last entry into the freed slot. Find and
// remove-by-value compare one slot per cycle; remove-by-value then copies the
// group of entries at the end over the matched group. Iterate emits each stored
// entry in turn. The result register holds while out_stall is high and the
// engine waits with it; the queue keeps accepting until two requests wait.
// Reset (rst, synchronous) empties the table and sets group_size to 1;
// table contents are not cleared and no clearing pass runs.
module unordered_swap_remove_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      action,
  input  logic [ustr_pkg::ValueWidth-1:0] item_value,
  input  logic [ustr_pkg::IdxWidth-1:0]   slot_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      status,
  output logic [ustr_pkg::IdxWidth-1:0]   out_index,
  output logic [ustr_pkg::ValueWidth-1:0] out_value,
  output logic [ustr_pkg::CntWidth-1:0]   entry_count,
  output logic                            group_end,
  output logic                            last
);
  import ustr_pkg::*;

  request_t in_req;
  request_t q_req;
  result_t  res;
  logic     q_valid;
  logic     q_pop;

  assign in_req.action     = action_t'(action);
  assign in_req.item_value = item_value;
  assign in_req.slot_index = slot_index;

  ustr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_req    (q_req)
  );

  ustr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_req     (q_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign status      = res.status;
  assign out_index   = res.out_index;
  assign out_value   = res.out_value;
  assign entry_count = res.entry_count;
  assign group_end   = res.group_end;
  assign last        = res.last;

endmodule

// File: verif/ustr_checker.sv
// Checker for the swap-remove table: predicts results from accepted requests and compares.
`timescale 1ns / 1ps
module ustr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  action,
  input  logic [31:0] item_value,
  input  logic [5:0]  slot_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [5:0]  out_index,
  input  logic [31:0] out_value,
  input  logic [6:0]  entry_count,
  input  logic        group_end,
  input  logic        last,
  output int          fail_count,
  output int          pending
);
  import ustr_pkg::*;

  logic [31:0] table_mem [Capacity];
  logic [6:0]  table_fill;
  logic [2:0]  grp_cfg;
  result_t     expected_results[$];

  function automatic result_t mk(int st, int idx, logic [31:0] v, int ge, int ls);
    result_t r;
    r.status = 3'(st);
    r.out_index = 6'(idx);
    r.out_value = v;
    r.entry_count = table_fill;
    r.group_end = 1'(ge);
    r.last = 1'(ls);
    return r;
  endfunction

  task automatic predict_request(logic [2:0] act, logic [31:0] v, logic [5:0] idx);
    int g;
    int hit;
    int n;
    g = (grp_cfg == 0) ? 1 : grp_cfg;
    hit = -1;
    for (int i = 0; i < table_fill; i++)
      if (hit < 0 && table_mem[i] == v) hit = i;
    case (action_t'(act))
      ACT_ADD: begin
        if (table_fill >= Capacity) begin
          expected_results.push_back(mk(ST_FULL, 0, 0, 0, 1));
        end else begin
          table_mem[table_fill] = v;
          table_fill = table_fill + 7'd1;
          expected_results.push_back(mk(ST_OK, table_fill - 1, 0, 0, 1));
        end
      end
      ACT_REMOVE: begin
        if (table_fill == 0) begin
          expected_results.push_back(mk(ST_EMPTY, idx, 0, 0, 1));
        end else if (idx >= table_fill) begin
          expected_results.push_back(mk(ST_BADINDEX, idx, 0, 0, 1));
        end else begin
          table_fill = table_fill - 7'd1;
          table_mem[idx] = table_mem[table_fill];
          expected_results.push_back(mk(ST_OK, idx, 0, 0, 1));
        end
      end
      ACT_REMGRP: begin
        if (hit < 0) begin
          expected_results.push_back(mk(ST_NOTFOUND, 0, 0, 0, 1));
        end else if (table_fill < g || hit + g > table_fill) begin
          expected_results.push_back(mk(ST_BADINDEX, hit, 0, 0, 1));
        end else begin
          for (int j = 0; j < g; j++) table_mem[hit + j] = table_mem[table_fill - g + j];
          table_fill = table_fill - 7'(g);
          expected_results.push_back(mk(ST_OK, hit, 0, 0, 1));
        end
      end
      ACT_FIND: begin
        if (hit < 0) expected_results.push_back(mk(ST_NOTFOUND, 0, 0, 0, 1));
        else expected_results.push_back(mk(ST_OK, hit, 0, 0, 1));
      end
      ACT_ITER: begin
        n = table_fill;
        if (n == 0) expected_results.push_back(mk(ST_EMPTY, 0, 0, 0, 1));
        for (int i = 0; i < n; i++)
          expected_results.push_back(mk(ST_OK, i, table_mem[i],
                                        ((i + 1) % g == 0) || (i + 1 == n), i + 1 == n));
      end
      ACT_CLEAR: begin
        table_fill = '0;
        expected_results.push_back(mk(ST_OK, 0, 0, 0, 1));
      end
      default: expected_results.push_back(mk(ST_OK, 0, 0, 0, 1));
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      table_fill = '0;
      grp_cfg = 3'd1;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we) grp_cfg = cfg_wdata;
      if (in_valid && !in_stall) predict_request(action, item_value, slot_index);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual status %0d idx %0d",
                   $time, status, out_index);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want != {status, out_index, out_value, entry_count, group_end, last}) begin
            $display("%0t mismatch: expected st %0d idx %0d val %h cnt %0d ge %0d last %0d",
                     $time, want.status, want.out_index, want.out_value,
                     want.entry_count, want.group_end, want.last);
            $display("%0t           actual st %0d idx %0d val %h cnt %0d ge %0d last %0d",
                     $time, status, out_index, out_value, entry_count, group_end, last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// File: verif/tb_top.sv
// Testbench top for the swap-remove table: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module tb_top;
  import ustr_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  action;
  logic [31:0] item_value;
  logic [5:0]  slot_index;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [5:0]  out_index;
  logic [31:0] out_value;
  logic [6:0]  entry_count;
  logic        group_end;
  logic        last;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  longint      cycle_count;
  logic [31:0] value_pool [8];

  unordered_swap_remove_table dut (.*);
  ustr_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (cycle_count > 2000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_request(action_t act, int unsigned v, int idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    action <= act;
    item_value <= v;
    slot_index <= 6'(idx);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_then_config(logic [2:0] g);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_request();
    int r;
    logic [31:0] v;
    r = $urandom_range(99);
    v = ($urandom_range(3) == 0) ? $urandom() : value_pool[$urandom_range(7)];
    if (r < 40) send_request(ACT_ADD, v, $urandom_range(63));
    else if (r < 55) send_request(ACT_REMOVE, v, $urandom_range(3) == 0 ?
                                  $urandom_range(63) : $urandom_range(15));
    else if (r < 70) send_request(ACT_REMGRP, v, $urandom_range(63));
    else if (r < 83) send_request(ACT_FIND, v, $urandom_range(63));
    else if (r < 92) send_request(ACT_ITER, v, $urandom_range(63));
    else if (r < 95) send_request(ACT_CLEAR, v, $urandom_range(63));
    else send_request(action_t'($urandom_range(6, 7)), v, $urandom_range(63));
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    in_valid = 0;
    action = 0;
    item_value = 0;
    slot_index = 0;
    out_stall = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (value_pool[i]) value_pool[i] = $urandom();
    value_pool[0] = 32'h0;
    value_pool[1] = 32'hFFFF_FFFF;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty-table cases, extremes, every action
    send_request(ACT_REMOVE, 0, 0);
    send_request(ACT_FIND, 0, 0);
    send_request(ACT_REMGRP, 0, 0);
    send_request(ACT_ITER, 0, 0);
    send_request(ACT_ADD, 32'h0, 63);
    send_request(ACT_ADD, 32'hFFFF_FFFF, 0);
    send_request(ACT_ADD, 32'hA5A5_5A5A, 0);
    send_request(ACT_FIND, 32'hFFFF_FFFF, 0);
    send_request(ACT_REMOVE, 0, 63);
    send_request(ACT_REMOVE, 0, 0);
    send_request(ACT_ITER, 0, 0);
    send_request(ACT_NOP6, 0, 0);
    send_request(ACT_NOP7, 32'hFFFF_FFFF, 63);
    drain_then_config(3'd7);
    send_request(ACT_REMGRP, 32'hA5A5_5A5A, 0);
    for (int i = 0; i < 65; i++) send_request(ACT_ADD, 32'(i), 0);
    send_request(ACT_ITER, 0, 0);
    send_request(ACT_REMGRP, 32'd60, 0);
    send_request(ACT_REMGRP, 32'd2, 0);
    send_request(ACT_CLEAR, 0, 0);
    drain_then_config(3'd0);
    for (int i = 0; i < 5; i++) send_request(ACT_ADD, 32'd9, 0);
    send_request(ACT_REMGRP, 32'd9, 0);
    send_request(ACT_ITER, 0, 0);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 77 : 0;
      recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 30 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        drain_then_config(3'($urandom_range(7)));
        for (int k = 0; k < 22; k++) random_request();
      end
    end

    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
